@@ rtl/gauss_jordan_row_reduction_defines.svh @@
// assertion macros for the gauss jordan row reduction block
// no dependencies; included by files that carry concurrent assertions
`ifndef GAUSS_JORDAN_ROW_REDUCTION_DEFINES_SVH
`define GAUSS_JORDAN_ROW_REDUCTION_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GJR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gauss jordan row reduction: assertion failed");
`define GJR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gauss jordan row reduction: assertion failed");
`else
`define GJR_ASSERT_SAME(label, clk, rst, ante, cons)
`define GJR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/gjr_pkg.sv @@
// shared constants, types and arithmetic helpers of the row reduction block
// no dependencies
`default_nettype none
package gjr_pkg;

   localparam int ROWS  = 4;
   localparam int COLS  = 4;
   localparam int RCW   = $clog2(ROWS + 1);
   localparam int RIW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW    = $clog2(COLS + 1);
   localparam int DEPTH = ROWS * (COLS + 1);
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DIV_STEPS = 63;

   typedef enum logic [1:0] {
      CSR_ACTIVE_ROWS    = 2'd0,
      CSR_ACTIVE_COLS    = 2'd1,
      CSR_ZERO_THRESHOLD = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      WSEL_REQ, WSEL_RD, WSEL_A, WSEL_RES
   } wsel_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_FWD_ROW, ST_COL, ST_SRCH_INIT, ST_SRCH_RD, ST_SRCH_CMP,
      ST_SW_RA, ST_SW_RB, ST_SW_WA, ST_SW_WB, ST_TEST,
      ST_EL_ROW, ST_EL_F, ST_EL_RS, ST_EL_RT, ST_EL_MUL, ST_EL_DIV, ST_EL_WAIT, ST_EL_WR,
      ST_BWD_ROW, ST_BWD_P,
      ST_NRM_ROW, ST_NRM_P, ST_NRM_RD, ST_NRM_DIV, ST_NRM_WAIT, ST_NRM_WR,
      ST_OUT_RD, ST_OUT_WR
   } state_type;

   typedef struct packed {
      logic [2:0] row;
      logic [2:0] col;
      logic       is_rhs;
      logic       col_free;
      logic       has_pivot;
      logic [2:0] pivot_col;
      logic       last;
   } rsp_meta_type;

   typedef struct packed {
      logic          rd_en;
      logic [AW-1:0] rd_addr;
      logic          we;
      logic [AW-1:0] wr_addr;
      wsel_type      wr_sel;
      logic          ld_best;
      logic          ld_a;
      logic          ld_s;
      logic          ld_f;
      logic          ld_t;
      logic          ld_p;
      logic          p_from_best;
      logic          mul_en;
      logic          div_start;
      logic          div_norm;
      logic          rsp_load;
      rsp_meta_type  meta;
   } cmd_type;

   typedef struct packed {
      logic gt;
      logic rd_zero;
      logic best_zero;
      logic div_done;
      logic div_busy;
      logic rsp_free;
   } status_type;

   function automatic logic [AW-1:0] mem_addr(input logic [RIW-1:0] row,
                                              input logic [CW-1:0] col);
      return AW'(int'(row) * (COLS + 1) + int'(col));
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [32:0] x;
      x = v[31] ? (33'd0 - {1'b1, v}) : {1'b0, v};
      return x[31:0];
   endfunction

   function automatic logic is_zero(input logic signed [31:0] v, input logic [15:0] thr);
      return (v == 32'sd0) || (mag32(v) < {16'd0, thr});
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
      if (!v[64] && (v[63:31] != '0)) begin
         return 32'sh7FFF_FFFF;
      end else if (v[64] && (v[63:31] != '1)) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

endpackage
`default_nettype wire

@@ rtl/gauss_jordan_row_reduction.sv @@
// gauss jordan row reduction with partial pivoting, signed q16.16
// top level: size registers, sequencer gjr_ctrl and datapath gjr_datapath
// depends on gjr_pkg and gauss_jordan_row_reduction_defines.svh
//
// usage:
// - csr channel writes active_rows, active_cols and zero_threshold; always ready;
//   it must only be written while the block is idle, which is not enforced
// - req channel loads one matrix element per cycle while idle; a request with
//   load_last set starts the reduction and req_ready drops until readout ends
// - reduction runs on a single-port matrix memory; every elimination and
//   normalization update goes through one 64 by 32 divider that retires one
//   quotient bit per cycle; a 4 by 4 system of full rank takes 76 updates
// - rsp channel then returns rows in order: coefficients, then the rhs entry;
//   each entry is read from memory, then loaded into the result register
// - a stalled rsp_ready holds the result register and pauses the readout
// - reset clears sequencer, pivot flags, size and threshold regs (4, 4, 1);
//   the matrix memory itself is not cleared and must be loaded before use
`default_nettype none
`include "gauss_jordan_row_reduction_defines.svh"
module gauss_jordan_row_reduction (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_row_index,
   input  wire logic [2:0]         req_col_index,
   input  wire logic signed [31:0] req_element_value,
   input  wire logic               req_is_rhs,
   input  wire logic               req_load_last,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_out_row,
   output logic [2:0]              rsp_out_col,
   output logic signed [31:0]      rsp_out_value,
   output logic                    rsp_out_is_rhs,
   output logic                    rsp_col_free,
   output logic                    rsp_row_has_pivot,
   output logic [2:0]              rsp_row_pivot_col,
   output logic                    rsp_out_last,
   // configuration channel
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_data
);

   logic [3:0]  active_rows_ff;
   logic [2:0]  active_cols_ff;
   logic [15:0] zero_threshold_ff;
   gjr_pkg::cmd_type    dp_cmd;
   gjr_pkg::status_type dp_status;

   assign csr_ready = 1'b1;

   // size and threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_rows_ff    <= 4'd4;
         active_cols_ff    <= 3'd4;
         zero_threshold_ff <= 16'd1;
      end else if (csr_valid) begin
         unique case (gjr_pkg::csr_index_type'(csr_index))
            gjr_pkg::CSR_ACTIVE_ROWS:    active_rows_ff    <= csr_data[3:0];
            gjr_pkg::CSR_ACTIVE_COLS:    active_cols_ff    <= csr_data[2:0];
            gjr_pkg::CSR_ZERO_THRESHOLD: zero_threshold_ff <= csr_data;
            default: ;
         endcase
      end
   end

   gjr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_row_index (req_row_index),
      .req_col_index (req_col_index),
      .req_is_rhs    (req_is_rhs),
      .req_load_last (req_load_last),
      .active_rows   (active_rows_ff),
      .active_cols   (active_cols_ff),
      .status        (dp_status),
      .cmd           (dp_cmd)
   );

   gjr_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .req_element_value (req_element_value),
      .zero_threshold    (zero_threshold_ff),
      .status            (dp_status),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_is_rhs    (rsp_out_is_rhs),
      .rsp_col_free      (rsp_col_free),
      .rsp_row_has_pivot (rsp_row_has_pivot),
      .rsp_row_pivot_col (rsp_row_pivot_col),
      .rsp_out_last      (rsp_out_last)
   );

   // the last request starts a run, so loading stops at once
   `GJR_ASSERT_NEXT(a_busy_after_last, clock, reset, req_valid && req_ready && req_load_last, !req_ready)
   // while loading, only the final result of the previous run may still wait
   `GJR_ASSERT_SAME(a_idle_only_last_pending, clock, reset, rsp_valid && !rsp_out_last, !req_ready)
   // the divider is never left running once the sequencer is idle
   `GJR_ASSERT_SAME(a_div_idle_when_loading, clock, reset, req_ready, !dp_status.div_busy)

endmodule
`default_nettype wire

@@ rtl/gjr_div.sv @@
// iterative signed 64 by 32 divider, one quotient bit per cycle, truncating
// depends on gjr_pkg
`default_nettype none
module gjr_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [63:0] dividend,
   input  wire logic signed [31:0] divisor,
   output logic                    busy,
   output logic                    done,
   output logic signed [63:0]      quotient
);

   logic        busy_ff, done_ff, neg_ff;
   logic [5:0]  cnt_ff;
   logic [62:0] quo_ff;
   logic [31:0] rem_ff, dvs_ff;
   logic [63:0] dd_mag;
   logic [32:0] trial, diff;

   assign dd_mag = dividend[63] ? (64'd0 - dividend) : dividend;
   assign trial  = {rem_ff, quo_ff[62]};
   assign diff   = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 6'd1;
         if (cnt_ff == 6'(gjr_pkg::DIV_STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dd_mag[62:0];
         rem_ff <= '0;
         dvs_ff <= gjr_pkg::mag32(divisor);
         neg_ff <= dividend[63] ^ divisor[31];
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_ff <= diff[31:0];
            quo_ff <= {quo_ff[61:0], 1'b1};
         end else begin
            rem_ff <= trial[31:0];
            quo_ff <= {quo_ff[61:0], 1'b0};
         end
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? (64'sd0 - $signed({1'b0, quo_ff})) : $signed({1'b0, quo_ff});

endmodule
`default_nettype wire

@@ rtl/gjr_datapath.sv @@
// matrix memory, operand registers, multiplier, divider and result register
// depends on gjr_pkg and gjr_div
`default_nettype none
module gjr_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire gjr_pkg::cmd_type       cmd,
   input  wire logic signed [31:0]     req_element_value,
   input  wire logic [15:0]            zero_threshold,
   output gjr_pkg::status_type         status,
   input  wire logic                   rsp_ready,
   output logic                        rsp_valid,
   output logic [2:0]                  rsp_out_row,
   output logic [2:0]                  rsp_out_col,
   output logic signed [31:0]          rsp_out_value,
   output logic                        rsp_out_is_rhs,
   output logic                        rsp_col_free,
   output logic                        rsp_row_has_pivot,
   output logic [2:0]                  rsp_row_pivot_col,
   output logic                        rsp_out_last
);

   logic signed [31:0] mem_ff [gjr_pkg::DEPTH];
   logic signed [31:0] rd_data_ff, best_ff, a_ff, s_ff, f_ff, t_ff, p_ff;
   logic signed [63:0] prod_ff, dividend, quotient;
   logic signed [64:0] res_wide;
   logic signed [31:0] wr_data;
   logic               norm_ff, div_busy, div_done, rsp_valid_ff;
   gjr_pkg::rsp_meta_type meta_ff;
   logic signed [31:0] value_ff;

   gjr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (p_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   assign dividend = cmd.div_norm ? {{16{rd_data_ff[31]}}, rd_data_ff, 16'd0} : prod_ff;

   // elimination is t - s*f/p, normalization is v*2^16/p
   assign res_wide = norm_ff ? {quotient[63], quotient}
                             : ({{33{t_ff[31]}}, t_ff} - {quotient[63], quotient});

   always_comb begin
      unique case (cmd.wr_sel)
         gjr_pkg::WSEL_REQ: wr_data = req_element_value;
         gjr_pkg::WSEL_RD:  wr_data = rd_data_ff;
         gjr_pkg::WSEL_A:   wr_data = a_ff;
         gjr_pkg::WSEL_RES: wr_data = gjr_pkg::sat32(res_wide);
         default:           wr_data = req_element_value;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem_ff[cmd.wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[cmd.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_best) best_ff <= rd_data_ff;
      if (cmd.ld_a)    a_ff    <= rd_data_ff;
      if (cmd.ld_s)    s_ff    <= rd_data_ff;
      if (cmd.ld_f)    f_ff    <= rd_data_ff;
      if (cmd.ld_t)    t_ff    <= rd_data_ff;
      if (cmd.ld_p)    p_ff    <= cmd.p_from_best ? best_ff : rd_data_ff;
      if (cmd.mul_en)  prod_ff <= s_ff * f_ff;
      if (cmd.div_start) norm_ff <= cmd.div_norm;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         meta_ff  <= cmd.meta;
         value_ff <= rd_data_ff;
      end
   end

   assign status.gt        = gjr_pkg::mag32(rd_data_ff) > gjr_pkg::mag32(best_ff);
   assign status.rd_zero   = gjr_pkg::is_zero(rd_data_ff, zero_threshold);
   assign status.best_zero = gjr_pkg::is_zero(best_ff, zero_threshold);
   assign status.div_done  = div_done;
   assign status.div_busy  = div_busy;
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_row       = meta_ff.row;
   assign rsp_out_col       = meta_ff.col;
   assign rsp_out_value     = value_ff;
   assign rsp_out_is_rhs    = meta_ff.is_rhs;
   assign rsp_col_free      = meta_ff.col_free;
   assign rsp_row_has_pivot = meta_ff.has_pivot;
   assign rsp_row_pivot_col = meta_ff.pivot_col;
   assign rsp_out_last      = meta_ff.last;

endmodule
`default_nettype wire

@@ rtl/gjr_ctrl.sv @@
// sequencer: load, pivot search and swap, elimination, normalization, readout
// depends on gjr_pkg
`default_nettype none
module gjr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [2:0]           req_row_index,
   input  wire logic [2:0]           req_col_index,
   input  wire logic                 req_is_rhs,
   input  wire logic                 req_load_last,
   input  wire logic [3:0]           active_rows,
   input  wire logic [2:0]           active_cols,
   input  wire gjr_pkg::status_type  status,
   output gjr_pkg::cmd_type          cmd
);

   localparam int RCW = gjr_pkg::RCW;
   localparam int RIW = gjr_pkg::RIW;
   localparam int CW  = gjr_pkg::CW;

   gjr_pkg::state_type state_ff, state_in;
   logic [RCW-1:0] r_ff, r_in, i_ff, i_in, e_ff, e_in, m_val;
   logic [RIW-1:0] big_ff, big_in, rr, rm1;
   logic [CW-1:0]  c_ff, c_in, j_ff, j_in, start_ff, start_in, n_val, j_next, out_col;
   logic           bwd_ff, bwd_in;
   logic           found_ff [gjr_pkg::ROWS];
   logic           found_in [gjr_pkg::ROWS];
   logic [CW-1:0]  pcol_ff  [gjr_pkg::ROWS];
   logic [CW-1:0]  pcol_in  [gjr_pkg::ROWS];
   logic           j_end, out_rhs, col_used, req_in_range;

   // clamp the size registers into range
   always_comb begin
      if (active_rows == 4'd0) begin
         m_val = RCW'(1);
      end else if (int'(active_rows) > gjr_pkg::ROWS) begin
         m_val = RCW'(gjr_pkg::ROWS);
      end else begin
         m_val = RCW'(active_rows);
      end
      if (active_cols == 3'd0) begin
         n_val = CW'(1);
      end else if (int'(active_cols) > gjr_pkg::COLS) begin
         n_val = CW'(gjr_pkg::COLS);
      end else begin
         n_val = CW'(active_cols);
      end
   end

   assign rr     = r_ff[RIW-1:0];
   assign rm1    = RIW'(r_ff - RCW'(1));
   assign j_end  = (j_ff == CW'(gjr_pkg::COLS));
   assign j_next = (CW'(j_ff + CW'(1)) == n_val) ? CW'(gjr_pkg::COLS) : CW'(j_ff + CW'(1));
   assign out_rhs = (j_ff == n_val);
   assign out_col = out_rhs ? CW'(gjr_pkg::COLS) : j_ff;
   assign req_in_range = (int'(req_row_index) < gjr_pkg::ROWS) &&
                         (req_is_rhs || (int'(req_col_index) < gjr_pkg::COLS));

   always_comb begin
      col_used = 1'b0;
      for (int k = 0; k < gjr_pkg::ROWS; k++) begin
         if (found_ff[k] && (pcol_ff[k] == j_ff)) col_used = 1'b1;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gjr_pkg::ST_IDLE:
            if (req_valid && req_load_last) state_in = gjr_pkg::ST_FWD_ROW;
         gjr_pkg::ST_FWD_ROW:
            state_in = (r_ff == m_val) ? gjr_pkg::ST_BWD_ROW : gjr_pkg::ST_COL;
         gjr_pkg::ST_COL:
            state_in = (c_ff >= n_val) ? gjr_pkg::ST_FWD_ROW : gjr_pkg::ST_SRCH_INIT;
         gjr_pkg::ST_SRCH_INIT: state_in = gjr_pkg::ST_SRCH_RD;
         gjr_pkg::ST_SRCH_RD: begin
            if (i_ff == m_val) begin
               state_in = (big_ff == rr) ? gjr_pkg::ST_TEST : gjr_pkg::ST_SW_RA;
            end else begin
               state_in = gjr_pkg::ST_SRCH_CMP;
            end
         end
         gjr_pkg::ST_SRCH_CMP: state_in = gjr_pkg::ST_SRCH_RD;
         gjr_pkg::ST_SW_RA:    state_in = gjr_pkg::ST_SW_RB;
         gjr_pkg::ST_SW_RB:    state_in = gjr_pkg::ST_SW_WA;
         gjr_pkg::ST_SW_WA:    state_in = gjr_pkg::ST_SW_WB;
         gjr_pkg::ST_SW_WB:
            state_in = j_end ? gjr_pkg::ST_TEST : gjr_pkg::ST_SW_RA;
         gjr_pkg::ST_TEST:
            state_in = status.best_zero ? gjr_pkg::ST_COL : gjr_pkg::ST_EL_ROW;
         gjr_pkg::ST_EL_ROW: begin
            if (bwd_ff) begin
               state_in = (e_ff == '0) ? gjr_pkg::ST_BWD_ROW : gjr_pkg::ST_EL_F;
            end else begin
               state_in = (RCW'(e_ff + RCW'(1)) == m_val) ? gjr_pkg::ST_FWD_ROW
                                                          : gjr_pkg::ST_EL_F;
            end
         end
         gjr_pkg::ST_EL_F:    state_in = gjr_pkg::ST_EL_RS;
         gjr_pkg::ST_EL_RS:   state_in = gjr_pkg::ST_EL_RT;
         gjr_pkg::ST_EL_RT:   state_in = gjr_pkg::ST_EL_MUL;
         gjr_pkg::ST_EL_MUL:  state_in = gjr_pkg::ST_EL_DIV;
         gjr_pkg::ST_EL_DIV:  state_in = gjr_pkg::ST_EL_WAIT;
         gjr_pkg::ST_EL_WAIT:
            if (status.div_done) state_in = gjr_pkg::ST_EL_WR;
         gjr_pkg::ST_EL_WR:
            state_in = j_end ? gjr_pkg::ST_EL_ROW : gjr_pkg::ST_EL_RS;
         gjr_pkg::ST_BWD_ROW: begin
            if (r_ff == '0) begin
               state_in = gjr_pkg::ST_NRM_ROW;
            end else if (found_ff[rm1]) begin
               state_in = gjr_pkg::ST_BWD_P;
            end
         end
         gjr_pkg::ST_BWD_P:
            state_in = status.rd_zero ? gjr_pkg::ST_BWD_ROW : gjr_pkg::ST_EL_ROW;
         gjr_pkg::ST_NRM_ROW: begin
            if (r_ff == m_val) begin
               state_in = gjr_pkg::ST_OUT_RD;
            end else if (found_ff[rr]) begin
               state_in = gjr_pkg::ST_NRM_P;
            end
         end
         gjr_pkg::ST_NRM_P:
            state_in = status.rd_zero ? gjr_pkg::ST_NRM_ROW : gjr_pkg::ST_NRM_RD;
         gjr_pkg::ST_NRM_RD:  state_in = gjr_pkg::ST_NRM_DIV;
         gjr_pkg::ST_NRM_DIV: state_in = gjr_pkg::ST_NRM_WAIT;
         gjr_pkg::ST_NRM_WAIT:
            if (status.div_done) state_in = gjr_pkg::ST_NRM_WR;
         gjr_pkg::ST_NRM_WR:
            state_in = j_end ? gjr_pkg::ST_NRM_ROW : gjr_pkg::ST_NRM_RD;
         gjr_pkg::ST_OUT_RD: state_in = gjr_pkg::ST_OUT_WR;
         gjr_pkg::ST_OUT_WR: begin
            if (status.rsp_free) begin
               if (out_rhs && (RCW'(r_ff + RCW'(1)) == m_val)) begin
                  state_in = gjr_pkg::ST_IDLE;
               end else begin
                  state_in = gjr_pkg::ST_OUT_RD;
               end
            end
         end
         default: state_in = gjr_pkg::ST_IDLE;
      endcase
   end

   // commands and counter updates
   always_comb begin
      cmd       = '0;
      cmd.wr_sel = gjr_pkg::WSEL_REQ;
      req_ready = 1'b0;
      r_in = r_ff;  i_in = i_ff;  e_in = e_ff;  big_in = big_ff;
      c_in = c_ff;  j_in = j_ff;  start_in = start_ff;  bwd_in = bwd_ff;
      for (int k = 0; k < gjr_pkg::ROWS; k++) begin
         found_in[k] = found_ff[k];
         pcol_in[k]  = pcol_ff[k];
      end
      unique case (state_ff)
         gjr_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.we      = req_valid && req_in_range;
            cmd.wr_addr = gjr_pkg::mem_addr(req_row_index[RIW-1:0],
                             req_is_rhs ? CW'(gjr_pkg::COLS) : req_col_index[CW-1:0]);
            if (req_valid && req_load_last) begin
               r_in = '0;
               start_in = '0;
               for (int k = 0; k < gjr_pkg::ROWS; k++) begin
                  found_in[k] = 1'b0;
                  pcol_in[k]  = '0;
               end
            end
         end
         gjr_pkg::ST_FWD_ROW: c_in = start_ff;
         gjr_pkg::ST_COL: begin
            if (c_ff >= n_val) begin
               r_in = RCW'(r_ff + RCW'(1));
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = gjr_pkg::mem_addr(rr, c_ff);
            end
         end
         gjr_pkg::ST_SRCH_INIT: begin
            cmd.ld_best = 1'b1;
            big_in = rr;
            i_in   = RCW'(r_ff + RCW'(1));
         end
         gjr_pkg::ST_SRCH_RD: begin
            j_in = '0;
            if (i_ff != m_val) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = gjr_pkg::mem_addr(i_ff[RIW-1:0], c_ff);
            end
         end
         gjr_pkg::ST_SRCH_CMP: begin
            // strict compare keeps the first row on a tie
            if (status.gt) begin
               cmd.ld_best = 1'b1;
               big_in = i_ff[RIW-1:0];
            end
            i_in = RCW'(i_ff + RCW'(1));
         end
         gjr_pkg::ST_SW_RA: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = gjr_pkg::mem_addr(rr, j_ff);
         end
         gjr_pkg::ST_SW_RB: begin
            cmd.ld_a    = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = gjr_pkg::mem_addr(big_ff, j_ff);
         end
         gjr_pkg::ST_SW_WA: begin
            cmd.we      = 1'b1;
            cmd.wr_sel  = gjr_pkg::WSEL_RD;
            cmd.wr_addr = gjr_pkg::mem_addr(rr, j_ff);
         end
         gjr_pkg::ST_SW_WB: begin
            cmd.we      = 1'b1;
            cmd.wr_sel  = gjr_pkg::WSEL_A;
            cmd.wr_addr = gjr_pkg::mem_addr(big_ff, j_ff);
            j_in = j_next;
         end
         gjr_pkg::ST_TEST: begin
            if (status.best_zero) begin
               c_in = CW'(c_ff + CW'(1));
            end else begin
               found_in[rr] = 1'b1;
               pcol_in[rr]  = c_ff;
               start_in     = CW'(c_ff + CW'(1));
               cmd.ld_p        = 1'b1;
               cmd.p_from_best = 1'b1;
               e_in   = r_ff;
               bwd_in = 1'b0;
            end
         end
         gjr_pkg::ST_EL_ROW: begin
            if (bwd_ff) begin
               if (e_ff != '0) begin
                  e_in        = RCW'(e_ff - RCW'(1));
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = gjr_pkg::mem_addr(RIW'(e_ff - RCW'(1)), c_ff);
               end
            end else if (RCW'(e_ff + RCW'(1)) == m_val) begin
               r_in = RCW'(r_ff + RCW'(1));
            end else begin
               e_in        = RCW'(e_ff + RCW'(1));
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = gjr_pkg::mem_addr(RIW'(e_ff + RCW'(1)), c_ff);
            end
         end
         gjr_pkg::ST_EL_F: begin
            cmd.ld_f = 1'b1;
            j_in = bwd_ff ? '0 : c_ff;
         end
         gjr_pkg::ST_EL_RS: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = gjr_pkg::mem_addr(rr, j_ff);
         end
         gjr_pkg::ST_EL_RT: begin
            cmd.ld_s    = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = gjr_pkg::mem_addr(e_ff[RIW-1:0], j_ff);
         end
         gjr_pkg::ST_EL_MUL: begin
            cmd.ld_t   = 1'b1;
            cmd.mul_en = 1'b1;
         end
         gjr_pkg::ST_EL_DIV: cmd.div_start = 1'b1;
         gjr_pkg::ST_EL_WAIT: ;
         gjr_pkg::ST_EL_WR: begin
            cmd.we      = 1'b1;
            cmd.wr_sel  = gjr_pkg::WSEL_RES;
            cmd.wr_addr = gjr_pkg::mem_addr(e_ff[RIW-1:0], j_ff);
            j_in = j_next;
         end
         gjr_pkg::ST_BWD_ROW: begin
            if (r_ff != '0) begin
               r_in = RCW'(r_ff - RCW'(1));
               if (found_ff[rm1]) begin
                  c_in        = pcol_ff[rm1];
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = gjr_pkg::mem_addr(rm1, pcol_ff[rm1]);
               end
            end
         end
         gjr_pkg::ST_BWD_P: begin
            cmd.ld_p = 1'b1;
            e_in   = r_ff;
            bwd_in = 1'b1;
         end
         gjr_pkg::ST_NRM_ROW: begin
            if (r_ff == m_val) begin
               r_in = '0;
               j_in = '0;
            end else if (found_ff[rr]) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_addr = gjr_pkg::mem_addr(rr, pcol_ff[rr]);
            end else begin
               r_in = RCW'(r_ff + RCW'(1));
            end
         end
         gjr_pkg::ST_NRM_P: begin
            cmd.ld_p = 1'b1;
            j_in = '0;
            if (status.rd_zero) r_in = RCW'(r_ff + RCW'(1));
         end
         gjr_pkg::ST_NRM_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = gjr_pkg::mem_addr(rr, j_ff);
         end
         gjr_pkg::ST_NRM_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_norm  = 1'b1;
         end
         gjr_pkg::ST_NRM_WAIT: ;
         gjr_pkg::ST_NRM_WR: begin
            cmd.we      = 1'b1;
            cmd.wr_sel  = gjr_pkg::WSEL_RES;
            cmd.wr_addr = gjr_pkg::mem_addr(rr, j_ff);
            j_in = j_next;
            if (j_end) r_in = RCW'(r_ff + RCW'(1));
         end
         gjr_pkg::ST_OUT_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = gjr_pkg::mem_addr(rr, out_col);
         end
         gjr_pkg::ST_OUT_WR: begin
            cmd.meta.row       = 3'(r_ff);
            cmd.meta.col       = out_rhs ? 3'd0 : 3'(j_ff);
            cmd.meta.is_rhs    = out_rhs;
            cmd.meta.col_free  = !out_rhs && !col_used;
            cmd.meta.has_pivot = found_ff[rr];
            cmd.meta.pivot_col = found_ff[rr] ? 3'(pcol_ff[rr]) : 3'd0;
            cmd.meta.last      = out_rhs && (RCW'(r_ff + RCW'(1)) == m_val);
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               if (out_rhs) begin
                  j_in = '0;
                  r_in = RCW'(r_ff + RCW'(1));
               end else begin
                  j_in = CW'(j_ff + CW'(1));
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gjr_pkg::ST_IDLE;
         r_ff <= '0;  i_ff <= '0;  e_ff <= '0;  big_ff <= '0;
         c_ff <= '0;  j_ff <= '0;  start_ff <= '0;  bwd_ff <= 1'b0;
         for (int k = 0; k < gjr_pkg::ROWS; k++) begin
            found_ff[k] <= 1'b0;
            pcol_ff[k]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         r_ff <= r_in;  i_ff <= i_in;  e_ff <= e_in;  big_ff <= big_in;
         c_ff <= c_in;  j_ff <= j_in;  start_ff <= start_in;  bwd_ff <= bwd_in;
         for (int k = 0; k < gjr_pkg::ROWS; k++) begin
            found_ff[k] <= found_in[k];
            pcol_ff[k]  <= pcol_in[k];
         end
      end
   end

endmodule
`default_nettype wire
